[design/iir_transposed_df2_filter_defines.svh]
// Assertion macros shared by the IIR filter design files.
`ifndef IIR_TRANSPOSED_DF2_FILTER_DEFINES_SVH
`define IIR_TRANSPOSED_DF2_FILTER_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define IIRTDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define IIRTDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/iirtdf_pkg.sv]
// Shared types and constants of the transposed direct form II IIR filter.
package iirtdf_pkg;

  localparam int unsigned ORDER_DEF = 2;
  localparam int unsigned ORDER_MAX = 3;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned TAP_W    = 40;
  // Sum of a tap and two products, with headroom for the saturation check.
  localparam int unsigned SUM_W    = TAP_W + 2;
  localparam int unsigned FRAC_W   = 14;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_B0 = 3'd0;
  localparam logic [2:0] REG_B1 = 3'd1;
  localparam logic [2:0] REG_B2 = 3'd2;
  localparam logic [2:0] REG_B3 = 3'd3;
  localparam logic [2:0] REG_A1 = 3'd4;
  localparam logic [2:0] REG_A2 = 3'd5;
  localparam logic [2:0] REG_A3 = 3'd6;

  localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

  // Step strobes handed from the sequencer to every cell.
  typedef struct packed {
    logic mul_x;
    logic mul_y;
    logic upd;
  } cell_ctrl_t;

endpackage

[design/iirtdf_cell.sv]
// One tap cell: holds a 40-bit tap, shares one multiplier for the feedforward and feedback terms.
module iirtdf_cell
  import iirtdf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_W-1:0] x_i,
  input  logic signed [SAMPLE_W-1:0] y_i,
  input  logic signed [COEF_W-1:0]   b_i,
  input  logic signed [COEF_W-1:0]   a_i,
  input  logic signed [TAP_W-1:0]    tap_next_i,
  output logic signed [TAP_W-1:0]    tap_o,
  output logic                       sat_o
);

  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   xb_q;
  logic signed [PROD_W-1:0]   ya_q;
  logic signed [SUM_W-1:0]    sum;
  logic signed [TAP_W-1:0]    tap_q;
  logic signed [TAP_W-1:0]    tap_d;

  assign mul_a = ctrl_i.mul_y ? y_i : x_i;
  assign mul_b = ctrl_i.mul_y ? a_i : b_i;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_x) begin
      xb_q <= prod;
    end
    if (ctrl_i.mul_y) begin
      ya_q <= prod;
    end
  end

  // The top three bits of the sum disagree exactly when it leaves the 40-bit range.
  always_comb begin
    sum   = SUM_W'(tap_next_i) + SUM_W'(xb_q) - SUM_W'(ya_q);
    sat_o = (sum[SUM_W-1:TAP_W-1] != '0) && (sum[SUM_W-1:TAP_W-1] != '1);
    if (sat_o) begin
      tap_d = sum[SUM_W-1] ? {1'b1, {(TAP_W-1){1'b0}}} : {1'b0, {(TAP_W-1){1'b1}}};
    end else begin
      tap_d = sum[TAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (ctrl_i.upd) begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

[design/iir_transposed_df2_filter.sv]
// Top level of the transposed direct form II IIR filter: registers, sequencer and cell row.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid / tready        | tdata[15:0] sample_in
//  m_axis    | out       | tvalid / tready        | tdata[15:0] sample_out, tuser clipped
//  apb       | in        | psel, penable, pready  | paddr[4:2] register, pwdata[17:0]
//
// An item's result is loaded into the output register with the tap update, and the next item
// is taken after that: one step multiplies the sample by b0 and by every cell's b, one rounds
// and saturates the output, one forms the feedback products, and one updates the taps.
// A new item is taken only while the sequencer is idle; a waiting result does not block it.
// If the previous result is still not taken, the tap update step waits for the output slot.
// Reset clears the taps, the sequencer and the output valid, and restores the coefficients.
module iir_transposed_df2_filter
  import iirtdf_pkg::*;
#(
  parameter int unsigned ORDER = ORDER_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] sample_in
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] sample_out
  output logic              m_axis_tuser,   // [0] clipped
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  `include "iir_transposed_df2_filter_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_OUT  = 3'd2;
  localparam logic [2:0] S_FB   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  // Coefficient registers.
  logic signed [COEF_W-1:0] b_q [ORDER_MAX+1];
  logic signed [COEF_W-1:0] a_q [ORDER_MAX];
  logic [2:0]               reg_idx;
  logic                     cfg_wr;
  logic [COEF_W-1:0]        rd_coef;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q[0] <= B0_RESET;
      b_q[1] <= '0;
      b_q[2] <= '0;
      b_q[3] <= '0;
      a_q[0] <= '0;
      a_q[1] <= '0;
      a_q[2] <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_B0:  b_q[0] <= pwdata[COEF_W-1:0];
        REG_B1:  b_q[1] <= pwdata[COEF_W-1:0];
        REG_B2:  b_q[2] <= pwdata[COEF_W-1:0];
        REG_B3:  b_q[3] <= pwdata[COEF_W-1:0];
        REG_A1:  a_q[0] <= pwdata[COEF_W-1:0];
        REG_A2:  a_q[1] <= pwdata[COEF_W-1:0];
        REG_A3:  a_q[2] <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_B0:  rd_coef = b_q[0];
      REG_B1:  rd_coef = b_q[1];
      REG_B2:  rd_coef = b_q[2];
      REG_B3:  rd_coef = b_q[3];
      REG_A1:  rd_coef = a_q[0];
      REG_A2:  rd_coef = a_q[1];
      REG_A3:  rd_coef = a_q[2];
      default: rd_coef = '0;
    endcase
  end

  assign prdata = {{(DATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef};

  // Sequencer.
  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       in_acc;
  logic       out_free;
  logic       load_out;
  cell_ctrl_t ctrl;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign load_out      = (state_q == S_UPD) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MUL;
      S_MUL:   state_d = S_OUT;
      S_OUT:   state_d = S_FB;
      S_FB:    state_d = S_UPD;
      S_UPD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl.mul_x = (state_q == S_MUL);
  assign ctrl.mul_y = (state_q == S_FB);
  assign ctrl.upd   = load_out;

  // Datapath for the output sample.
  logic signed [SAMPLE_W-1:0]       x_q;
  logic signed [PROD_W-1:0]         p0_q;
  logic signed [SUM_W-1:0]          acc;
  logic signed [SUM_W-FRAC_W-1:0]   y_full;
  logic                             y_sat;
  logic signed [SAMPLE_W-1:0]       y_sat_val;
  logic signed [SAMPLE_W-1:0]       y_q;
  logic                             clip_q;
  logic signed [TAP_W-1:0]          taps [ORDER];
  logic [ORDER-1:0]                 tap_sat;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= s_axis_tdata;
    end
    if (state_q == S_MUL) begin
      p0_q <= x_q * b_q[0];
    end
  end

  // Round half up, then an arithmetic shift gives the floor.
  always_comb begin
    acc    = SUM_W'(taps[0]) + SUM_W'(p0_q) + SUM_W'(1 << (FRAC_W - 1));
    y_full = acc[SUM_W-1:FRAC_W];
    y_sat  = (y_full[SUM_W-FRAC_W-1:SAMPLE_W-1] != '0) &&
             (y_full[SUM_W-FRAC_W-1:SAMPLE_W-1] != '1);
    if (y_sat) begin
      y_sat_val = y_full[SUM_W-FRAC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat_val = y_full[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      y_q    <= y_sat_val;
      clip_q <= y_sat;
    end
  end

  // Row of tap cells; each cell adds its right neighbor's old tap.
  for (genvar i = 0; i < ORDER; i++) begin : g_cell
    logic signed [TAP_W-1:0] tap_next;
    if (i == ORDER - 1) begin : g_last
      assign tap_next = '0;
    end else begin : g_mid
      assign tap_next = taps[i+1];
    end

    iirtdf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .x_i        (x_q),
      .y_i        (y_q),
      .b_i        (b_q[i+1]),
      .a_i        (a_q[i]),
      .tap_next_i (tap_next),
      .tap_o      (taps[i]),
      .sat_o      (tap_sat[i])
    );
  end

  // Output register.
  logic        m_valid_q;
  logic [15:0] m_data_q;
  logic        m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= y_q;
      m_user_q <= clip_q || (|tap_sat);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `IIRTDF_ASSERT(a_accept_starts, in_acc |=> state_q == S_MUL, "accepted item did not start")
  `IIRTDF_ASSERT(a_result_from_upd, $rose(m_axis_tvalid) |-> $past(state_q) == S_UPD,
                 "result appeared outside the update step")
  `IIRTDF_ASSERT(a_upd_waits, (state_q == S_UPD) && m_axis_tvalid && !m_axis_tready
                 |=> state_q == S_UPD, "tap update ran over a pending result")
  `IIRTDF_ASSERT(a_fb_follows_out, state_q == S_OUT |=> state_q == S_FB,
                 "feedback step did not follow the output step")
  `IIRTDF_ASSERT_ALWAYS(a_ready_idle, s_axis_tready |-> !ctrl.upd && !ctrl.mul_y,
                        "input ready while cells are busy")

endmodule

[dv/iir_transposed_df2_filter_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the transposed direct form II IIR filter with a built-in predictor.
module iir_transposed_df2_filter_test;
  import iirtdf_pkg::*;

  localparam int unsigned N_TAPS          = ORDER_DEF;
  localparam int unsigned N_DIR           = 34;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 230;
  localparam int unsigned IDLE_GUARD      = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam logic [2:0]  REG_UNUSED      = 3'd7;
  localparam longint      TAP_MAX         = (longint'(1) <<< (TAP_W - 1)) - 1;
  localparam longint      TAP_MIN         = -TAP_MAX - 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;
  } filt_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_TYPED, ROW_PREDICT} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [2:0]          idx;
    logic [DATA_W-1:0]   value;
    logic [SAMPLE_W-1:0] exp_sample;
    logic                exp_clip;
  } dir_row_t;

  typedef enum int {
    COEF_DEFAULT, COEF_SMALL, COEF_FULL, COEF_ALL_MAX, COEF_ALL_MIN, COEF_CORNERS
  } coef_set_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;  // [15:0] sample_in
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [15:0] sample_out
  logic              m_axis_tuser;        // [0] clipped
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Predictor state: coefficients as the block holds them, and the taps.
  logic signed [COEF_W-1:0] coef_b [4]      = '{B0_RESET, '0, '0, '0};
  logic signed [COEF_W-1:0] coef_a [4]      = '{'0, '0, '0, '0};
  logic signed [TAP_W-1:0]  tap_q  [N_TAPS] = '{default: '0};

  filt_result_t expected_samples [$];
  int unsigned  fail_count   = 0;
  int unsigned  stall_cycles = 0;
  bit           no_idle      = 1'b0;
  bit           hold_off_req = 1'b0;

  dir_row_t dir_rows [N_DIR] = '{
    // Reset coefficients pass the sample through unchanged.
    '{ROW_TYPED,   REG_B0, 32'h0000_7FFF, 16'h7FFF, 1'b0},
    '{ROW_TYPED,   REG_B0, 32'h0000_8000, 16'h8000, 1'b0},
    '{ROW_TYPED,   REG_B0, 32'h0000_0000, 16'h0000, 1'b0},
    '{ROW_TYPED,   REG_B0, 32'h0000_0001, 16'h0001, 1'b0},
    '{ROW_TYPED,   REG_B0, 32'h0000_FFFF, 16'hFFFF, 1'b0},
    // Largest gain; the upper word bits are junk and must be ignored.
    '{ROW_WRITE,   REG_B0, 32'hABC5_FFFF, 16'h0000, 1'b0},
    '{ROW_TYPED,   REG_B0, 32'h0000_7FFF, 16'h7FFF, 1'b1},
    '{ROW_TYPED,   REG_B0, 32'h0000_8000, 16'h8000, 1'b1},
    '{ROW_TYPED,   REG_B0, 32'h0000_0000, 16'h0000, 1'b0},
    // Most negative gain flips the saturation direction.
    '{ROW_WRITE,   REG_B0, 32'hFFFE_0000, 16'h0000, 1'b0},
    '{ROW_TYPED,   REG_B0, 32'h0000_7FFF, 16'h8000, 1'b1},
    '{ROW_TYPED,   REG_B0, 32'h0000_8000, 16'h7FFF, 1'b1},
    // A write past the last register must leave b0 untouched.
    '{ROW_WRITE,   REG_UNUSED, 32'h0000_4000, 16'h0000, 1'b0},
    '{ROW_TYPED,   REG_B0, 32'h0000_0001, 16'hFFF8, 1'b0},
    // Extreme feedforward and feedback coefficients, b3 and a3 unused.
    '{ROW_WRITE,   REG_B0, 32'h0000_4000, 16'h0000, 1'b0},
    '{ROW_WRITE,   REG_B1, 32'h0001_FFFF, 16'h0000, 1'b0},
    '{ROW_WRITE,   REG_B2, 32'h0002_0000, 16'h0000, 1'b0},
    '{ROW_WRITE,   REG_A1, 32'h0001_FFFF, 16'h0000, 1'b0},
    '{ROW_WRITE,   REG_A2, 32'h0002_0000, 16'h0000, 1'b0},
    '{ROW_WRITE,   REG_B3, 32'h0001_FFFF, 16'h0000, 1'b0},
    '{ROW_WRITE,   REG_A3, 32'h0002_0000, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_7FFF, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_8000, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_7FFF, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_0000, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_FFFF, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_3039, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_0000, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_0000, 16'h0000, 1'b0},
    // A gain of one half puts odd samples exactly on a rounding tie.
    '{ROW_WRITE,   REG_B0, 32'h0000_2000, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_0001, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_FFFF, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_0003, 16'h0000, 1'b0},
    '{ROW_PREDICT, REG_B0, 32'h0000_FFFD, 16'h0000, 1'b0}
  };

  iir_transposed_df2_filter #(
    .ORDER(ORDER_DEF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  // Computes the filtered sample for one input and advances the taps.
  function automatic filt_result_t next_filtered(logic [SAMPLE_W-1:0] smp);
    longint       xs;
    longint       acc;
    longint       y;
    longint       nt;
    filt_result_t res;
    xs          = $signed(smp);
    res.clipped = 1'b0;
    acc = longint'(tap_q[0]) + xs * longint'(coef_b[0]);
    y   = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (y > 32767) begin
      y           = 32767;
      res.clipped = 1'b1;
    end else if (y < -32768) begin
      y           = -32768;
      res.clipped = 1'b1;
    end
    // Ascending order reads each upper tap before it is overwritten.
    for (int i = 0; i < N_TAPS; i++) begin
      nt = xs * longint'(coef_b[i+1]) - y * longint'(coef_a[i+1]);
      if (i + 1 < N_TAPS) nt += longint'(tap_q[i+1]);
      if (nt > TAP_MAX) begin
        nt          = TAP_MAX;
        res.clipped = 1'b1;
      end else if (nt < TAP_MIN) begin
        nt          = TAP_MIN;
        res.clipped = 1'b1;
      end
      tap_q[i] = nt[TAP_W-1:0];
    end
    res.sample = y[SAMPLE_W-1:0];
    return res;
  endfunction

  task automatic write_coef(logic [2:0] idx, logic [DATA_W-1:0] word);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_B0, REG_B1, REG_B2, REG_B3: coef_b[idx[1:0]] = word[COEF_W-1:0];
      REG_A1, REG_A2, REG_A3:         coef_a[2'(idx - REG_A1 + 3'd1)] = word[COEF_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one item after a random gap and records its expectation once accepted.
  task automatic send_sample(logic [SAMPLE_W-1:0] smp, bit typed, filt_result_t typed_res);
    int unsigned  gap;
    int unsigned  roll;
    filt_result_t pred;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = next_filtered(smp);
    expected_samples.push_back(typed ? typed_res : pred);
  endtask

  // Stops offering items and lets the block finish its tap update.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (IDLE_GUARD) @(negedge clk_i);
  endtask

  always begin : ready_gen
    int unsigned len;
    @(negedge clk_i);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      m_axis_tready <= 1'b0;
      repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 35) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      m_axis_tready <= 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    filt_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected item: sample_out %0d, clipped %0d",
               $signed(m_axis_tdata), m_axis_tuser);
        fail_count++;
      end else begin
        exp_res = expected_samples.pop_front();
        if (m_axis_tdata !== exp_res.sample) begin
          $error("sample_out mismatch: expected %0d, actual %0d",
                 $signed(exp_res.sample), $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tuser !== exp_res.clipped) begin
          $error("clipped mismatch: expected %0d, actual %0d", exp_res.clipped, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : main
    logic [SAMPLE_W-1:0] smp;
    logic [DATA_W-1:0]   word;
    int                  v;
    coef_set_e           set_kind;
    smp = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_coef(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_sample(dir_rows[i].value[SAMPLE_W-1:0], dir_rows[i].kind == ROW_TYPED,
                    '{sample: dir_rows[i].exp_sample, clipped: dir_rows[i].exp_clip});
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_kind = coef_set_e'(p % 6);
      wait_idle();
      for (int r = REG_B0; r <= REG_A3; r++) begin
        case (set_kind)
          COEF_DEFAULT: v = (r == REG_B0) ? int'(B0_RESET) : 0;
          COEF_SMALL:   v = int'($urandom_range(0, 16384)) - 8192;
          COEF_FULL:    v = int'($urandom_range(0, 262143));
          COEF_ALL_MAX: v = 131071;
          COEF_ALL_MIN: v = -131072;
          default: begin
            case ($urandom_range(0, 4))
              0:       v = 131071;
              1:       v = -131072;
              2:       v = 0;
              3:       v = 16384;
              default: v = -16384;
            endcase
          end
        endcase
        word         = $urandom();
        word[COEF_W-1:0] = v[COEF_W-1:0];
        write_coef(r[2:0], word);
      end
      write_coef(REG_UNUSED, $urandom());

      no_idle = (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Long receiver stall while items keep coming, so the input side backs up.
        if (p == 1 && n == 20) hold_off_req = 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: smp = $urandom();
          6, 7:             smp = 16'($urandom_range(0, 512)) - 16'd256;
          8: begin
            case ($urandom_range(0, 4))
              0:       smp = 16'h7FFF;
              1:       smp = 16'h8000;
              2:       smp = 16'h0000;
              3:       smp = 16'h0001;
              default: smp = 16'hFFFF;
            endcase
          end
          default: ;  // repeat the last sample, a step input
        endcase
        send_sample(smp, 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
